FILE: sv/cum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cum_pkg: shared types and constants of the cache utility monitor.
// Holds sizes, command codes, controller states and control structs.
// ----------------------------------------------------------------------------
package cum_pkg;

  localparam int NumThreads = 4;
  localparam int Sets       = 64;
  localparam int Ways       = 16;
  localparam int TagBits    = 20;

  localparam int CmdW  = 3;
  localparam int ThrW  = 2;
  localparam int SetW  = 6;
  localparam int TagW  = 20;
  localparam int PosW  = 4;
  localparam int CntW  = 32;

  localparam int ThrIdxW = (NumThreads > 1) ? $clog2(NumThreads) : 1;
  localparam int SetIdxW = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int WayIdxW = $clog2(Ways);
  localparam int RowAddrW = ThrIdxW + SetIdxW;
  localparam int RowDepth = NumThreads * Sets;
  localparam int CntDepth = NumThreads * Ways;
  localparam int CntIdxW  = $clog2(CntDepth);

  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_ACCESS = 3'd0,
    CMD_HALVE  = 3'd1,
    CMD_RDPOS  = 3'd2,
    CMD_RDMISS = 3'd3,
    CMD_INVAL  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_HALVE,
    ST_COUNT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic     load;     // capture the request
    logic     rd_row;   // read the shadow row
    logic     update;   // write row, miss counters, read position counter
    logic     halve;    // walk the position counter memory
    logic     count;    // write position counter, capture read value
    logic     out_load; // capture the result
  } ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            hv_last; // last write of the halving walk
  } stat_t;

endpackage : cum_pkg
`default_nettype wire

FILE: sv/cum_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cum_req_if / cum_rsp_if: valid/ready channels of the utility monitor.
// ----------------------------------------------------------------------------
interface cum_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [1:0]  thread;
  logic [5:0]  set_index;
  logic [19:0] tag;
  logic        main_hit;
  logic [3:0]  position;
  modport source (output valid, cmd, thread, set_index, tag, main_hit, position,
                  input ready);
  modport sink (input valid, cmd, thread, set_index, tag, main_hit, position,
                output ready);
endinterface

interface cum_rsp_if;
  logic        valid;
  logic        ready;
  logic        shadow_hit;
  logic [3:0]  hit_position;
  logic [31:0] counter_value;
  modport source (output valid, shadow_hit, hit_position, counter_value,
                  input ready);
  modport sink (input valid, shadow_hit, hit_position, counter_value,
                output ready);
endinterface
`default_nettype wire

FILE: sv/cum_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cum_ctrl: controller of the utility monitor.
// Sequences accept, row read, update, counter walk, counter write and result hand-off.
// ----------------------------------------------------------------------------
module cum_ctrl import cum_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = (stat_i.cmd == CMD_HALVE) ? ST_HALVE : ST_COUNT;
      ST_HALVE:  if (stat_i.hv_last) state_d = ST_COUNT;
      ST_COUNT:  state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE:   begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_READ:   ctrl_o.rd_row = 1'b1;
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_HALVE:  ctrl_o.halve = 1'b1;
      ST_COUNT:  ctrl_o.count = 1'b1;
      ST_OUT:    begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default:   ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.load, ctrl_o.rd_row, ctrl_o.update, ctrl_o.halve, ctrl_o.count,
              ctrl_o.out_load}))
    else $error("multiple control phases");
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.rd_row |=> ctrl_o.update) else $error("update did not follow read");
  a_load_only_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> in_ready_o) else $error("load without ready");

endmodule : cum_ctrl
`default_nettype wire

FILE: sv/cum_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cum_dp: datapath of the utility monitor.
// Shadow tag rows and position counters in memories, miss counters in
// registers, result register.
// ----------------------------------------------------------------------------
module cum_dp import cum_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ctrl_t           ctrl_i,
  output stat_t                stat_o,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [ThrW-1:0] thread_i,
  input  wire logic [SetW-1:0] set_index_i,
  input  wire logic [TagW-1:0] tag_i,
  input  wire logic            main_hit_i,
  input  wire logic [PosW-1:0] position_i,
  output logic                 shadow_hit_o,
  output logic [PosW-1:0]      hit_position_o,
  output logic [CntW-1:0]      counter_value_o
);

  typedef logic [TagBits-1:0] tag_t;
  typedef tag_t [Ways-1:0]    tag_row_t;

  // Request registers.
  logic [CmdW-1:0] cmd_q;
  logic [ThrW-1:0] thr_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic            mhit_q;
  logic [PosW-1:0] pos_q;

  // Shadow row memory; tags are undefined until a valid bit covers them.
  tag_row_t            tag_mem [RowDepth];
  logic [Ways-1:0]     vld_mem [RowDepth];
  logic [RowDepth-1:0] row_init_q; // row written at least once since reset
  tag_row_t            row_tag_q;
  logic [Ways-1:0]     row_vld_q;
  logic                row_init_rd_q;

  logic [CntW-1:0] miss_cnt_q [NumThreads];

  logic                shadow_hit_q;
  logic [PosW-1:0]     hit_pos_q;
  logic [CntW-1:0]     cval_q;

  logic thr_ok, set_ok;
  logic [RowAddrW-1:0] row_addr;
  assign thr_ok = ({{(32-ThrW){1'b0}}, thr_q} < 32'(NumThreads));
  assign set_ok = ({{(32-SetW){1'b0}}, set_q} < 32'(Sets));
  assign row_addr = {thr_q[ThrIdxW-1:0], set_q[SetIdxW-1:0]};

  // Search.
  logic [Ways-1:0]    row_vld;
  logic [Ways-1:0]    match;
  logic               found;
  logic [WayIdxW-1:0] fpos;
  assign row_vld = row_init_rd_q ? row_vld_q : '0;
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      match[i] = row_vld[i] && (row_tag_q[i] == tag_q[TagBits-1:0]);
      if (match[i]) begin
        found = 1'b1;
        fpos  = WayIdxW'(i);
      end
    end
  end

  // Row rewrite: move to head on access, move to tail on invalidate.
  tag_row_t        new_tag;
  logic [Ways-1:0] new_vld;
  logic            row_we;
  logic            is_acc, is_inv;
  logic [WayIdxW-1:0] mpos;
  assign is_acc = (cmd_q == CMD_ACCESS) && thr_ok && set_ok;
  assign is_inv = (cmd_q == CMD_INVAL) && thr_ok && set_ok;
  assign mpos   = found ? fpos : WayIdxW'(Ways - 1);
  always_comb begin
    new_tag = row_tag_q;
    new_vld = row_vld;
    row_we  = 1'b0;
    if (is_acc) begin
      row_we = 1'b1;
      for (int k = 1; k < Ways; k++) begin
        if (WayIdxW'(k) <= mpos) begin
          new_tag[k] = row_tag_q[k-1];
          new_vld[k] = row_vld[k-1];
        end
      end
      new_tag[0] = found ? row_tag_q[fpos] : tag_q[TagBits-1:0];
      new_vld[0] = 1'b1;
    end else if (is_inv && found) begin
      row_we = 1'b1;
      for (int k = 0; k < Ways - 1; k++) begin
        if (WayIdxW'(k) >= fpos) begin
          new_tag[k] = row_tag_q[k+1];
          new_vld[k] = row_vld[k+1];
        end
      end
      new_tag[Ways-1] = row_tag_q[fpos];
      new_vld[Ways-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      thr_q  <= thread_i;
      set_q  <= set_index_i;
      tag_q  <= tag_i;
      mhit_q <= main_hit_i;
      pos_q  <= position_i;
    end
    if (ctrl_i.rd_row) begin
      row_tag_q <= tag_mem[row_addr];
      row_vld_q <= vld_mem[row_addr];
    end
    if (ctrl_i.update && row_we) begin
      tag_mem[row_addr] <= new_tag;
      vld_mem[row_addr] <= new_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q    <= '0;
      row_init_rd_q <= 1'b0;
    end else begin
      if (ctrl_i.rd_row) row_init_rd_q <= row_init_q[row_addr];
      if (ctrl_i.update && row_we) row_init_q[row_addr] <= 1'b1;
    end
  end

  // Position counters live in a memory with one registered read and one
  // write a cycle. Entries never written since reset read as zero. Halving
  // walks the memory, reading one entry while writing back the one before.
  logic [CntIdxW-1:0] hit_ci, rd_ci;
  assign hit_ci = {thr_q[ThrIdxW-1:0], fpos};
  assign rd_ci  = {thr_q[ThrIdxW-1:0], pos_q[WayIdxW-1:0]};

  logic [CntW-1:0]     pos_cnt_mem [CntDepth];
  logic [CntDepth-1:0] cnt_init_q;
  logic [CntW-1:0]     cnt_rd_q;
  logic                cnt_rd_init_q;
  logic [CntW-1:0]     cnt_val;
  logic [CntIdxW:0]    hv_idx_q;
  logic                hv_wr_q;
  logic [CntIdxW-1:0]  hv_addr_q;
  logic                hv_rd;
  logic                cnt_re;
  logic [CntIdxW-1:0]  cnt_raddr;
  logic                cnt_we;
  logic [CntIdxW-1:0]  cnt_waddr;
  logic [CntW-1:0]     cnt_wdata;

  assign cnt_val   = cnt_rd_init_q ? cnt_rd_q : '0;
  assign hv_rd     = ctrl_i.halve && (hv_idx_q < (CntIdxW+1)'(CntDepth));
  assign cnt_re    = ctrl_i.update || hv_rd;
  assign cnt_raddr = ctrl_i.halve ? hv_idx_q[CntIdxW-1:0] : (is_acc ? hit_ci : rd_ci);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = hit_ci;
    cnt_wdata = cnt_val + 1'b1;
    if (ctrl_i.halve) begin
      cnt_we    = hv_wr_q;
      cnt_waddr = hv_addr_q;
      cnt_wdata = cnt_val >> 1;
    end else if (ctrl_i.count) begin
      cnt_we = is_acc && found && (cnt_val != CntMax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_re) cnt_rd_q <= pos_cnt_mem[cnt_raddr];
    if (cnt_we) pos_cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_init_q    <= '0;
      cnt_rd_init_q <= 1'b0;
      hv_idx_q      <= '0;
      hv_wr_q       <= 1'b0;
      hv_addr_q     <= '0;
    end else begin
      if (cnt_re) cnt_rd_init_q <= cnt_init_q[cnt_raddr];
      if (cnt_we) cnt_init_q[cnt_waddr] <= 1'b1;
      if (ctrl_i.load) hv_idx_q <= '0;
      else if (hv_rd) hv_idx_q <= hv_idx_q + 1'b1;
      hv_wr_q <= hv_rd;
      if (hv_rd) hv_addr_q <= hv_idx_q[CntIdxW-1:0];
    end
  end

  // Miss counters, one per thread.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumThreads; i++) miss_cnt_q[i] <= '0;
    end else if (ctrl_i.update) begin
      if (cmd_q == CMD_HALVE && thr_ok) begin
        for (int i = 0; i < NumThreads; i++) miss_cnt_q[i] <= miss_cnt_q[i] >> 1;
      end else if (is_acc) begin
        if (!mhit_q && miss_cnt_q[thr_q[ThrIdxW-1:0]] != CntMax)
          miss_cnt_q[thr_q[ThrIdxW-1:0]] <= miss_cnt_q[thr_q[ThrIdxW-1:0]] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      shadow_hit_q <= (is_acc || is_inv) && found;
      hit_pos_q    <= ((is_acc || is_inv) && found) ? PosW'(fpos) : '0;
    end
    if (ctrl_i.count) begin
      cval_q <= '0;
      if (thr_ok && cmd_q == CMD_RDPOS &&
          {{(32-PosW){1'b0}}, pos_q} < 32'(Ways))
        cval_q <= cnt_val;
      else if (thr_ok && cmd_q == CMD_RDMISS)
        cval_q <= miss_cnt_q[thr_q[ThrIdxW-1:0]];
    end
    if (ctrl_i.out_load) begin
      shadow_hit_o    <= shadow_hit_q;
      hit_position_o  <= hit_pos_q;
      counter_value_o <= cval_q;
    end
  end

  assign stat_o.cmd     = cmd_q;
  assign stat_o.hv_last = hv_wr_q && !hv_rd;

  a_hit_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.update && !found |=> hit_pos_q == '0) else $error("stale hit position");
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.update && is_acc |-> $onehot0(match)) else $error("duplicate shadow tag");
  a_mru_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.update && is_acc |-> new_vld[0]) else $error("MRU entry not valid");

endmodule : cum_dp
`default_nettype wire

FILE: sv/cache_utility_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cache_utility_monitor: shadow tag utility monitor for way partitioning.
// Controller plus datapath; one command in flight at a time.
// ----------------------------------------------------------------------------
// Each command passes from acceptance to result through capture, read of
// the thread's shadow row from the row memory, update of the row and the miss
// counters together with a read of the position counter memory, write of the
// position counter, and transfer to the output register. The single row
// memory port, the read-modify-write of one row and the registered read of
// the position counter set this sequence. After the update, a halve command
// walks the 64 position counters, reading one entry and writing back the one
// before it each cycle. The next item is accepted once the result has
// moved into the output register, so a waiting result does not hold up the
// following item's capture. No clearing pass is needed after reset: a
// per-row written flag makes untouched rows read as all invalid, and a
// per-entry written flag makes untouched position counters read as zero.
// Counters saturate and halve together on the halve command.
module cache_utility_monitor import cum_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cum_req_if.sink   req,
  cum_rsp_if.source rsp
);

  ctrl_t ctrl;
  stat_t stat;

  cum_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_ready_i (rsp.ready),
    .out_valid_o (rsp.valid),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cum_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (req.cmd),
    .thread_i        (req.thread),
    .set_index_i     (req.set_index),
    .tag_i           (req.tag),
    .main_hit_i      (req.main_hit),
    .position_i      (req.position),
    .shadow_hit_o    (rsp.shadow_hit),
    .hit_position_o  (rsp.hit_position),
    .counter_value_o (rsp.counter_value)
  );

endmodule : cache_utility_monitor
`default_nettype wire
